>>> hw/rtl/sdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdq_pkg: shared types and constants of the searchable deque
// Storage depth, field widths, request and status codes, and the control
// word that steers every storage cell of the chain.
// ----------------------------------------------------------------------------
package sdq_pkg;

  // Storage depth and derived widths
  localparam int unsigned Depth = 64;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  // Fixed field widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 4;
  localparam int unsigned KthInW  = 8;
  localparam int unsigned KthW    = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CmpW    = (CntW > KthW) ? CntW : KthW;

  typedef enum logic [OpW-1:0] {
    OP_ADD_FRONT = 4'd0,
    OP_ADD_BACK  = 4'd1,
    OP_REM_FRONT = 4'd2,
    OP_REM_BACK  = 4'd3,
    OP_CONTAINS  = 4'd4,
    OP_INDEX_OF  = 4'd5,
    OP_SIZE      = 4'd6,
    OP_REVERSE   = 4'd7,
    OP_KTH       = 4'd8
  } sdq_op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } sdq_status_e;

  // Per-cycle command to every cell of the chain
  typedef struct packed {
    logic shift_up;    // take the lower neighbour's value
    logic shift_down;  // take the upper neighbour's value
    logic load;        // selected cell takes the new value
  } cell_ctrl_t;

endpackage : sdq_pkg
`default_nettype wire

>>> hw/rtl/sdq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdq_cell: one storage cell of the deque chain
// Holds one element; shifts from either neighbour or loads a new value.
// ----------------------------------------------------------------------------
module sdq_cell (
  input  logic                      clk_i,
  input  sdq_pkg::cell_ctrl_t       ctrl_i,
  input  logic                      sel_i,
  input  logic [sdq_pkg::DataW-1:0] lo_data_i,
  input  logic [sdq_pkg::DataW-1:0] hi_data_i,
  input  logic [sdq_pkg::DataW-1:0] new_data_i,
  output logic [sdq_pkg::DataW-1:0] data_o
);
  import sdq_pkg::*;

  logic [DataW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_up) begin
      data_d = lo_data_i;
    end else if (ctrl_i.shift_down) begin
      data_d = hi_data_i;
    end else if (ctrl_i.load && sel_i) begin
      data_d = new_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule : sdq_cell
`default_nettype wire

>>> hw/rtl/searchable_deque_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// searchable_deque_unit: bounded deque of signed 32-bit values with search
// Front/back add and remove, membership, index search, size, reverse and
// k-th element from the end, held in a chain of storage cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_* valid/ready channel (opcode, value, kth); each
//   transaction produces exactly one result transaction on the out_* channel
//   (status, found, position, element, count).
//   Elements sit in a chain of 64 cells, physical cell 0 being the front
//   while the direction flag is clear and cell count-1 the front while it is
//   set; reverse only flips the flag.
//   Add, remove, size, reverse and failed look-ups complete at once:
//   the result is registered at the edge that accepts the request.
//   Contains, index-of and a k-th look-up in range rotate the whole chain
//   once through cell 0, one cell per cycle, and register the result when
//   the rotation ends. Sustained rate is therefore one request per cycle
//   for the simple operations while each result is taken, and a search
//   takes no new request until its scan has handed over its result.
//   A new request is taken while a result waits only if that result is taken
//   in the same cycle; a stalled receiver holds the result and blocks input.
//   Reset empties the list and clears the direction flag; no clearing pass.
// ----------------------------------------------------------------------------
module searchable_deque_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         opcode_i,
  input  logic signed [31:0] value_i,
  input  logic signed [7:0]  kth_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               found_o,
  output logic [5:0]         position_o,
  output logic signed [31:0] element_o,
  output logic [6:0]         count_o
);
  import sdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;

  // List bookkeeping
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rev_q, rev_d;

  // Scan context
  logic [DataW-1:0] scan_val_q, scan_val_d;
  logic [IdxW-1:0]  scan_t_q, scan_t_d;
  logic [IdxW-1:0]  scan_tgt_q, scan_tgt_d;
  logic [IdxW-1:0]  scan_pos_q, scan_pos_d;
  logic [DataW-1:0] scan_elem_q, scan_elem_d;
  logic             scan_found_q, scan_found_d;
  logic             scan_kth_q, scan_kth_d;
  logic             scan_idx_q, scan_idx_d;

  // Result register
  logic               out_valid_q;
  logic [StatusW-1:0] status_q;
  logic               found_q;
  logic [PosW-1:0]    position_q;
  logic [DataW-1:0]   element_q;
  logic [CountW-1:0]  count_q;

  // Result being produced this cycle
  logic               res_load;
  sdq_status_e        res_status;
  logic               res_found;
  logic [IdxW-1:0]    res_pos;
  logic [DataW-1:0]   res_elem;

  // Cell chain
  cell_ctrl_t       cell_ctrl;
  logic [Depth-1:0] cell_sel;
  logic [DataW-1:0] cell_data [Depth];

  logic            in_accept;
  logic            full;
  logic            empty;
  logic [KthW-1:0] ku;
  logic            hit;
  logic            last_step;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_accept  = in_valid_i && in_ready_o;
  assign full       = (cnt_q == CntW'(Depth));
  assign empty      = (cnt_q == '0);

  // Clamp k to at least one
  assign ku = (kth_i < 8'sd1) ? KthW'(1) : kth_i[KthW-1:0];

  // Element passing cell 0 during a scan, limited to the occupied range
  assign hit       = (cell_data[0] == scan_val_q) && (CntW'(scan_t_q) < cnt_q);
  assign last_step = (scan_t_q == IdxW'(Depth - 1));

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rev_d        = rev_q;
    cell_ctrl    = '0;
    scan_val_d   = scan_val_q;
    scan_t_d     = scan_t_q;
    scan_tgt_d   = scan_tgt_q;
    scan_pos_d   = scan_pos_q;
    scan_elem_d  = scan_elem_q;
    scan_found_d = scan_found_q;
    scan_kth_d   = scan_kth_q;
    scan_idx_d   = scan_idx_q;
    res_load     = 1'b0;
    res_status   = ST_OK;
    res_found    = 1'b0;
    res_pos      = '0;
    res_elem     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_load = 1'b1;
          unique case (sdq_op_e'(opcode_i))
            OP_ADD_FRONT, OP_ADD_BACK: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                // Physical low end is the front unless reversed
                if ((sdq_op_e'(opcode_i) == OP_ADD_FRONT) != rev_q) begin
                  cell_ctrl.shift_up = 1'b1;
                end else begin
                  cell_ctrl.load = 1'b1;
                end
                cnt_d = cnt_q + CntW'(1);
              end
            end
            OP_REM_FRONT, OP_REM_BACK: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                // Drop at the low end by shifting down; high end by count only
                if ((sdq_op_e'(opcode_i) == OP_REM_FRONT) != rev_q) begin
                  cell_ctrl.shift_down = 1'b1;
                end
                cnt_d = cnt_q - CntW'(1);
              end
            end
            OP_CONTAINS, OP_INDEX_OF: begin
              if (!empty) begin
                res_load     = 1'b0;
                state_d      = S_SCAN;
                scan_val_d   = value_i;
                scan_t_d     = '0;
                scan_pos_d   = '0;
                scan_elem_d  = '0;
                scan_found_d = 1'b0;
                scan_kth_d   = 1'b0;
                scan_idx_d   = (sdq_op_e'(opcode_i) == OP_INDEX_OF);
              end
            end
            OP_SIZE: begin
            end
            OP_REVERSE: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                rev_d = !rev_q;
              end
            end
            OP_KTH: begin
              if (CmpW'(ku) <= CmpW'(cnt_q)) begin
                res_load     = 1'b0;
                state_d      = S_SCAN;
                scan_t_d     = '0;
                scan_pos_d   = '0;
                scan_elem_d  = '0;
                scan_found_d = 1'b1;
                scan_kth_d   = 1'b1;
                scan_idx_d   = 1'b0;
                scan_tgt_d   = rev_q ? IdxW'(ku - KthW'(1))
                                     : IdxW'(cnt_q - CntW'(ku));
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // Rotate the chain one cell towards cell 0
        cell_ctrl.shift_down = 1'b1;
        scan_t_d             = scan_t_q + IdxW'(1);
        if (scan_kth_q) begin
          if (scan_t_q == scan_tgt_q) begin
            scan_elem_d = cell_data[0];
          end
        end else if (hit) begin
          scan_found_d = 1'b1;
          // Reversed: the last physical hit is the first logical one
          if (rev_q) begin
            scan_pos_d = IdxW'(cnt_q - CntW'(1) - CntW'(scan_t_q));
          end else if (!scan_found_q) begin
            scan_pos_d = scan_t_q;
          end
        end
        if (last_step) begin
          state_d   = S_IDLE;
          res_load  = 1'b1;
          res_found = scan_found_d;
          res_pos   = scan_idx_q ? scan_pos_d : '0;
          res_elem  = scan_kth_q ? scan_elem_d : '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Cell chain: cell 0 takes the new value on a push at the low end and feeds the
  // top cell on rotation
  for (genvar j = 0; j < Depth; j++) begin : g_cell
    logic [DataW-1:0] lo_data;
    logic [DataW-1:0] hi_data;

    assign cell_sel[j] = (cnt_q == CntW'(j));

    if (j == 0) begin : g_lo_in
      assign lo_data = value_i;
    end else begin : g_lo_nb
      assign lo_data = cell_data[j-1];
    end

    if (j == Depth - 1) begin : g_hi_wrap
      assign hi_data = cell_data[0];
    end else begin : g_hi_nb
      assign hi_data = cell_data[j+1];
    end

    sdq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .sel_i      (cell_sel[j]),
      .lo_data_i  (lo_data),
      .hi_data_i  (hi_data),
      .new_data_i (value_i),
      .data_o     (cell_data[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      rev_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      scan_found_q <= 1'b0;
      scan_kth_q   <= 1'b0;
      scan_idx_q   <= 1'b0;
      scan_t_q     <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      rev_q        <= rev_d;
      scan_found_q <= scan_found_d;
      scan_kth_q   <= scan_kth_d;
      scan_idx_q   <= scan_idx_d;
      scan_t_q     <= scan_t_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_val_q  <= scan_val_d;
    scan_tgt_q  <= scan_tgt_d;
    scan_pos_q  <= scan_pos_d;
    scan_elem_q <= scan_elem_d;
    if (res_load) begin
      status_q   <= res_status;
      found_q    <= res_found;
      position_q <= PosW'(res_pos);
      element_q  <= res_elem;
      count_q    <= CountW'(cnt_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign position_o  = position_q;
  assign element_o   = element_q;
  assign count_o     = count_q;

  // Occupancy never passes the chain length
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("occupancy beyond depth");

  // A full rotation ends with a result and the chain back in place
  a_scan_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && last_step |=> (state_q == S_IDLE) && out_valid_q)
    else $error("scan did not deliver its result");

  // The direction flag only flips on a non-empty list
  a_rev_flip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rev_q != $past(rev_q)) |-> ($past(cnt_q) != '0))
    else $error("direction flipped on empty list");

  // Occupancy is left alone while a scan is rotating the storage
  a_scan_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> (cnt_q == $past(cnt_q)))
    else $error("occupancy changed during scan");

endmodule : searchable_deque_unit
`default_nettype wire
